>>> sv/rcpwm_pkg.sv
// Shared constants, register indexes and payload types for the RC pulse to H-bridge PWM block.
package rcpwm_pkg;

    localparam int PWM_PERIOD   = 1000;
    localparam int BLINK_DIV    = 100;
    localparam int HALF_PHASE   = (PWM_PERIOD / 2) + 1;
    localparam int FULL_MARGIN  = 20;
    localparam int PULSE_LOW    = 800;
    localparam int PULSE_HIGH   = 2200;

    localparam int CENTER_W     = 11;
    localparam int MAXW_W       = 12;
    localparam int DEADBAND_W   = 8;
    localparam int TIMEOUT_W    = 12;
    localparam int PULSE_W      = 16;
    localparam int PHASE_W      = 10;
    localparam int DUTY_W       = 10;
    localparam int BLINK_W      = 7;
    localparam int SILENCE_W    = 12;

    // Signed working width for the pulse decode arithmetic.
    localparam int EVAL_W       = 14;
    localparam int OFFSET_W     = 12;
    localparam int SPAN_W       = 12;
    localparam int DIVIDEND_W   = OFFSET_W + DUTY_W;
    localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);

    localparam int CENTER_RESET   = 1500;
    localparam int MAXW_RESET     = 1950;
    localparam int DEADBAND_RESET = 50;
    localparam int TIMEOUT_RESET  = 2000;

    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [1:0] REG_CENTER   = 2'd0;
    localparam logic [1:0] REG_MAXW     = 2'd1;
    localparam logic [1:0] REG_DEADBAND = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [PULSE_W-1:0] pulse_width;
    } cmd_t;

    typedef struct packed {
        logic               drive_a;
        logic               drive_b;
        logic               led;
        logic [PHASE_W-1:0] phase_length;
        logic               signal_lost;
    } rsp_t;

endpackage

>>> sv/rc_pulse_to_hbridge_pwm.sv
// RC pulse width to bidirectional H-bridge PWM: decode, restoring divider, phase timer and loss logic.
// A timer item passes through ST_TICK and ST_FINISH; a pulse item that is rejected or decodes
// to stop passes through ST_EVAL and ST_FINISH, a driving pulse with a positive offset through
// ST_EVAL, ST_MUL, the 22-step restoring divider in ST_DIV, ST_SAT and ST_FINISH. One item is in
// flight; the next transfer is taken the cycle after the result register loads.
// Reset (rst_n, asynchronous, active low): registers take their documented values, drive
// stays off, the phase register holds 501 and no result is pending.
module rc_pulse_to_hbridge_pwm
    import rcpwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_TICK   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_SAT    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    // Configuration registers.
    logic [CENTER_W-1:0]   center_reg;
    logic [MAXW_W-1:0]     maxw_reg;
    logic [DEADBAND_W-1:0] deadband_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;

    // Control state.
    logic [2:0]           state_reg, state_next;
    logic                 toggle_reg, toggle_next;
    logic                 stopped_reg, stopped_next;
    logic                 forward_reg, forward_next;
    logic                 full_fwd_reg, full_fwd_next;
    logic                 full_rev_reg, full_rev_next;
    logic                 seen_reg, seen_next;
    logic                 lost_reg, lost_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    logic [BLINK_W-1:0]   blink_reg, blink_next;
    logic [SILENCE_W-1:0] silence_reg, silence_next;
    logic                 led_reg, led_next;
    logic                 pin_a_reg, pin_a_next;
    logic                 pin_b_reg, pin_b_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Payload and datapath registers.
    logic [PULSE_W-1:0]    width_reg;
    logic                  kind_reg;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [SPAN_W:0]       rem_reg, rem_next;
    rsp_t                  rsp_reg;

    logic cmd_xfer;
    logic rsp_free;
    logic cfg_write;

    // Pulse decode arithmetic.
    logic                     pulse_ok;
    logic signed [EVAL_W-1:0] w_s, c_s, mx_s, db_s, mn_s, span_s;
    logic signed [EVAL_W-1:0] fwd_lim_s, rev_lim_s, wc_fwd_s, wc_rev_s, off_s;
    logic                     go_fwd, go_rev, full_fwd, full_rev;

    // Timer event arithmetic.
    logic                 tick_full, tick_on, tick_a, tick_b;
    logic [PHASE_W-1:0]   tick_phase;
    logic [BLINK_W-1:0]   blink_inc;
    logic [SILENCE_W:0]   silence_inc;

    // Divider step.
    logic [SPAN_W:0] trial;
    logic            trial_ge;

    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CENTER:   prdata = DATA_W'(center_reg);
            REG_MAXW:     prdata = DATA_W'(maxw_reg);
            REG_DEADBAND: prdata = DATA_W'(deadband_reg);
            REG_TIMEOUT:  prdata = DATA_W'(timeout_reg);
            default:      prdata = '0;
        endcase
    end

    // Pulse decode: direction, end clamp and offset from center. The width is only
    // meaningful when pulse_ok, so its low bits are enough for the signed view.
    always_comb
    begin
        pulse_ok  = (width_reg > PULSE_W'(PULSE_LOW)) && (width_reg < PULSE_W'(PULSE_HIGH));
        w_s       = $signed({1'b0, width_reg[EVAL_W-2:0]});
        c_s       = $signed(EVAL_W'(center_reg));
        mx_s      = $signed(EVAL_W'(maxw_reg));
        db_s      = $signed(EVAL_W'(deadband_reg));
        mn_s      = (c_s <<< 1) - mx_s;
        span_s    = mx_s - c_s;
        fwd_lim_s = mx_s - $signed(EVAL_W'(FULL_MARGIN));
        rev_lim_s = mn_s + $signed(EVAL_W'(FULL_MARGIN));
        go_fwd    = w_s > (c_s + db_s);
        go_rev    = w_s < (c_s - db_s);
        full_fwd  = w_s > fwd_lim_s;
        full_rev  = w_s < rev_lim_s;
        wc_fwd_s  = full_fwd ? fwd_lim_s : w_s;
        wc_rev_s  = full_rev ? rev_lim_s : w_s;
        off_s     = go_fwd ? (wc_fwd_s - c_s) : (c_s - wc_rev_s);
    end

    // Timer event: next phase, pin levels, LED and silence count.
    always_comb
    begin
        tick_full   = forward_reg ? full_fwd_reg : full_rev_reg;
        tick_on     = 1'b0;
        tick_phase  = PHASE_W'(HALF_PHASE);
        if (!stopped_reg)
        begin
            if (!toggle_reg)
            begin
                tick_on    = tick_full;
                tick_phase = tick_full ? PHASE_W'(HALF_PHASE) : (duty_reg + PHASE_W'(1));
            end
            else
            begin
                tick_on    = 1'b1;
                tick_phase = PHASE_W'(PWM_PERIOD + 1) - duty_reg;
            end
        end
        tick_a      = forward_reg && tick_on;
        tick_b      = !forward_reg && tick_on;
        blink_inc   = blink_reg + BLINK_W'(1);
        silence_inc = {1'b0, silence_reg} + (SILENCE_W + 1)'(1);
    end

    // One restoring divide step: bring down the next dividend bit.
    always_comb
    begin
        trial    = {rem_reg[SPAN_W-1:0], dvd_reg[DIVIDEND_W-1]};
        trial_ge = trial >= {1'b0, span_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        toggle_next    = toggle_reg;
        stopped_next   = stopped_reg;
        forward_next   = forward_reg;
        full_fwd_next  = full_fwd_reg;
        full_rev_next  = full_rev_reg;
        seen_next      = seen_reg;
        lost_next      = lost_reg;
        duty_next      = duty_reg;
        blink_next     = blink_reg;
        silence_next   = silence_reg;
        led_next       = led_reg;
        pin_a_next     = pin_a_reg;
        pin_b_next     = pin_b_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        offset_next    = offset_reg;
        span_next      = span_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = (cmd_data.kind == KIND_TICK) ? ST_TICK : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_FINISH;
                if (pulse_ok)
                begin
                    seen_next = 1'b1;
                    lost_next = 1'b0;
                    span_next = (span_s < $signed(EVAL_W'(1))) ? SPAN_W'(1) : span_s[SPAN_W-1:0];
                    if (go_fwd || go_rev)
                    begin
                        stopped_next = 1'b0;
                        forward_next = go_fwd;
                        if (go_fwd)
                        begin
                            full_fwd_next = full_fwd;
                        end
                        else
                        begin
                            full_rev_next = full_rev;
                        end
                        // Offset at or below zero: saturate duty at zero, skip the divide.
                        if (off_s > $signed(EVAL_W'(0)))
                        begin
                            offset_next = off_s[OFFSET_W-1:0];
                            state_next  = ST_MUL;
                        end
                        else
                        begin
                            duty_next = '0;
                        end
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                dvd_next   = DIVIDEND_W'(offset_reg) * DIVIDEND_W'(PWM_PERIOD);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? (trial - {1'b0, span_reg}) : trial;
                dvd_next = {dvd_reg[DIVIDEND_W-2:0], trial_ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                duty_next  = (dvd_reg > DIVIDEND_W'(PWM_PERIOD)) ? DUTY_W'(PWM_PERIOD)
                                                                 : dvd_reg[DUTY_W-1:0];
                state_next = ST_FINISH;
            end
            ST_TICK:
            begin
                toggle_next = !toggle_reg;
                pin_a_next  = tick_a;
                pin_b_next  = tick_b;
                phase_next  = tick_phase;
                if (lost_reg)
                begin
                    if (blink_inc == BLINK_W'(BLINK_DIV))
                    begin
                        blink_next = '0;
                        led_next   = !led_reg;
                    end
                    else
                    begin
                        blink_next = blink_inc;
                    end
                end
                else
                begin
                    led_next = tick_a || tick_b;
                end
                if (seen_reg)
                begin
                    silence_next = '0;
                end
                else if (silence_inc > {1'b0, timeout_reg})
                begin
                    silence_next = timeout_reg;
                    stopped_next = 1'b1;
                    lost_next    = 1'b1;
                end
                else
                begin
                    silence_next = silence_inc[SILENCE_W-1:0];
                end
                seen_next  = 1'b0;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hold until the result register is free.
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg    <= CENTER_W'(CENTER_RESET);
            maxw_reg      <= MAXW_W'(MAXW_RESET);
            deadband_reg  <= DEADBAND_W'(DEADBAND_RESET);
            timeout_reg   <= TIMEOUT_W'(TIMEOUT_RESET);
            state_reg     <= ST_IDLE;
            toggle_reg    <= 1'b0;
            stopped_reg   <= 1'b1;
            forward_reg   <= 1'b0;
            full_fwd_reg  <= 1'b0;
            full_rev_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            lost_reg      <= 1'b0;
            duty_reg      <= '0;
            blink_reg     <= '0;
            silence_reg   <= '0;
            led_reg       <= 1'b0;
            pin_a_reg     <= 1'b0;
            pin_b_reg     <= 1'b0;
            phase_reg     <= PHASE_W'(HALF_PHASE);
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    REG_CENTER:   center_reg   <= pwdata[CENTER_W-1:0];
                    REG_MAXW:     maxw_reg     <= pwdata[MAXW_W-1:0];
                    REG_DEADBAND: deadband_reg <= pwdata[DEADBAND_W-1:0];
                    REG_TIMEOUT:  timeout_reg  <= pwdata[TIMEOUT_W-1:0];
                    default:      center_reg   <= center_reg;
                endcase
            end
            state_reg     <= state_next;
            toggle_reg    <= toggle_next;
            stopped_reg   <= stopped_next;
            forward_reg   <= forward_next;
            full_fwd_reg  <= full_fwd_next;
            full_rev_reg  <= full_rev_next;
            seen_reg      <= seen_next;
            lost_reg      <= lost_next;
            duty_reg      <= duty_next;
            blink_reg     <= blink_next;
            silence_reg   <= silence_next;
            led_reg       <= led_next;
            pin_a_reg     <= pin_a_next;
            pin_b_reg     <= pin_b_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            kind_reg  <= cmd_data.kind;
            width_reg <= cmd_data.pulse_width;
        end
        offset_reg <= offset_next;
        span_reg   <= span_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        if (state_reg == ST_FINISH && rsp_free)
        begin
            rsp_reg.drive_a      <= pin_a_reg;
            rsp_reg.drive_b      <= pin_b_reg;
            rsp_reg.led          <= led_reg;
            rsp_reg.phase_length <= phase_reg;
            rsp_reg.signal_lost  <= lost_reg;
        end
    end

`ifndef SYNTHESIS
    a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> (state_reg == ST_TICK || state_reg == ST_EVAL))
        else $error("transfer did not start processing");

    a_kind_routes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> (kind_reg == KIND_TICK))
        else $error("timer path entered for a pulse item");

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_W'(PWM_PERIOD))
        else $error("duty above period");

    a_lost_stops: assert property (@(posedge clk) disable iff (!rst_n)
        lost_reg |-> stopped_reg)
        else $error("signal lost while drive enabled");

    a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
        !(pin_a_reg && pin_b_reg))
        else $error("both half-bridges driven");
`endif

endmodule
